// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl, compiled out with NO_ASSERTIONS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/msls_pkg.sv =====
// shared constants, codes and types of the multi-strip led serializer
package msls_pkg;

    localparam int LEDS_PER_STRIP = 16;
    localparam int STRIPS         = 5;
    localparam int BITS_PER_LED   = 24;
    localparam int COLOR_W        = 24;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int KIND_W         = 3;
    localparam int FIELD_W        = 8;
    localparam int LEVELS_W       = 8;
    localparam int ADDR_W         = (LEDS_PER_STRIP > 1) ? $clog2(LEDS_PER_STRIP) : 1;
    localparam int LED_W          = $clog2(LEDS_PER_STRIP + 1);
    localparam int STRIP_W        = (STRIPS > 1) ? $clog2(STRIPS) : 1;
    localparam int BIT_W          = $clog2(BITS_PER_LED);
    localparam int QDEPTH         = 4;
    localparam int QPTR_W         = $clog2(QDEPTH);

    localparam logic [CFG_W-1:0] DEF_PRESCALE    = CFG_W'(0);
    localparam logic [CFG_W-1:0] DEF_SLOT_PERIOD = CFG_W'(89);
    localparam logic [CFG_W-1:0] DEF_ZERO_HIGH   = CFG_W'(30);
    localparam logic [CFG_W-1:0] DEF_ONE_HIGH    = CFG_W'(60);

    typedef enum logic [KIND_W-1:0] {
        KIND_SET_PIXEL  = 3'd0,
        KIND_FILL_STRIP = 3'd1,
        KIND_SET_COLUMN = 3'd2,
        KIND_SET_ALL    = 3'd3,
        KIND_START      = 3'd4,
        KIND_TICK       = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PIXEL,
        OP_FILL,
        OP_COLUMN,
        OP_ALL,
        OP_START,
        OP_TICK
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESCALE  = 2'd0,
        CFG_PERIOD    = 2'd1,
        CFG_ZERO_HIGH = 2'd2,
        CFG_ONE_HIGH  = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_COPY,
        ST_FLUSH,
        ST_PRIME,
        ST_LOAD
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [STRIP_W-1:0] strip;
        logic [ADDR_W-1:0]  index;
        logic [COLOR_W-1:0] grb;
    } t_cmd;

    typedef struct packed {
        logic               we;
        t_cfg_reg           idx;
        logic [CFG_W-1:0]   data;
    } t_cfg_wr;

    typedef struct packed {
        logic idle;
        logic sending;
    } t_back_sts;

endpackage

// ===== rtl/core/msls_ram.sv =====
// generic simple dual-port ram with registered read
module msls_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/msls_front.sv =====
// front end: classifies incoming items and queues them for the back end
module msls_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [msls_pkg::KIND_W-1:0]    i_kind,
    input  logic [msls_pkg::FIELD_W-1:0]   i_strip,
    input  logic [msls_pkg::FIELD_W-1:0]   i_index,
    input  logic [msls_pkg::FIELD_W-1:0]   i_red,
    input  logic [msls_pkg::FIELD_W-1:0]   i_green,
    input  logic [msls_pkg::FIELD_W-1:0]   i_blue,
    input  logic                           i_pop,
    output logic                           o_full,
    output logic                           o_valid,
    output msls_pkg::t_cmd                 o_cmd
);

    msls_pkg::t_cmd                 w_cmd;
    logic                           w_strip_ok;
    logic                           w_index_ok;
    msls_pkg::t_cmd                 r_q [msls_pkg::QDEPTH];
    logic [msls_pkg::QPTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [msls_pkg::QPTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [msls_pkg::QPTR_W:0]      r_count, n_count;

    // range checks, out of range writes become no-ops
    assign w_strip_ok = (i_strip < msls_pkg::FIELD_W'(msls_pkg::STRIPS));
    assign w_index_ok = (i_index < msls_pkg::FIELD_W'(msls_pkg::LEDS_PER_STRIP));

    always_comb begin
        w_cmd.op    = msls_pkg::OP_NOP;
        w_cmd.strip = i_strip[msls_pkg::STRIP_W-1:0];
        w_cmd.index = i_index[msls_pkg::ADDR_W-1:0];
        w_cmd.grb   = {i_green, i_red, i_blue};
        case (msls_pkg::t_kind'(i_kind))
            msls_pkg::KIND_SET_PIXEL: begin
                if (w_strip_ok && w_index_ok) begin
                    w_cmd.op = msls_pkg::OP_PIXEL;
                end
            end
            msls_pkg::KIND_FILL_STRIP: begin
                if (w_strip_ok) begin
                    w_cmd.op = msls_pkg::OP_FILL;
                end
            end
            msls_pkg::KIND_SET_COLUMN: begin
                if (w_index_ok) begin
                    w_cmd.op = msls_pkg::OP_COLUMN;
                end
            end
            msls_pkg::KIND_SET_ALL: w_cmd.op = msls_pkg::OP_ALL;
            msls_pkg::KIND_START:   w_cmd.op = msls_pkg::OP_START;
            msls_pkg::KIND_TICK:    w_cmd.op = msls_pkg::OP_TICK;
            default:                w_cmd.op = msls_pkg::OP_NOP;
        endcase
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + msls_pkg::QPTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + msls_pkg::QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + (msls_pkg::QPTR_W+1)'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - (msls_pkg::QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    assign o_full  = (r_count == (msls_pkg::QPTR_W+1)'(msls_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_q[r_rd_ptr];

endmodule

// ===== rtl/core/msls_back.sv =====
// back end: pixel and send stores, slot timer and line encoder
module msls_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  msls_pkg::t_cfg_wr                i_cfg,
    input  logic                             i_q_valid,
    input  msls_pkg::t_cmd                   i_cmd,
    output logic                             o_pop,
    output msls_pkg::t_back_sts              o_sts,
    output logic                             o_done,
    output logic [msls_pkg::LEVELS_W-1:0]    o_line_levels,
    output logic                             o_busy_res
);

    localparam int L  = msls_pkg::LEDS_PER_STRIP;
    localparam int S  = msls_pkg::STRIPS;
    localparam int AW = msls_pkg::ADDR_W;
    localparam int CW = msls_pkg::COLOR_W;

    // configuration
    logic [msls_pkg::CFG_W-1:0]  r_prescale, r_period, r_zero_high, r_one_high;

    // control
    msls_pkg::t_state            r_state, n_state;
    logic [AW-1:0]               r_cnt, n_cnt;
    logic                        r_done, n_done;
    logic                        r_sending, n_sending;
    logic [msls_pkg::CFG_W-1:0]  r_pre, n_pre;
    logic [msls_pkg::CFG_W-1:0]  r_slot, n_slot;
    logic [msls_pkg::LED_W-1:0]  r_led, n_led;
    logic [msls_pkg::BIT_W-1:0]  r_bit, n_bit;
    logic                        r_cpy_wr;
    logic [AW-1:0]               r_cpy_addr;
    logic                        w_pop;
    logic                        w_ld_cmd;
    logic                        w_ld_cur;

    // payload
    msls_pkg::t_cmd              r_cmd;
    logic [CW-1:0]               r_cur [S];
    logic [S-1:0]                r_vld_q;
    logic [L-1:0]                r_pix_vld [S];

    // store ports
    logic [S-1:0]                w_pix_we;
    logic [AW-1:0]               w_pix_waddr;
    logic [CW-1:0]               w_pix_wdata;
    logic [AW-1:0]               w_pix_raddr;
    logic [CW-1:0]               w_pix_rdata [S];
    logic [AW-1:0]               w_snd_raddr;
    logic [CW-1:0]               w_snd_rdata [S];
    logic [CW-1:0]               w_snd_wdata [S];

    logic                        w_in_data;
    logic [S-1:0]                w_lvl;
    logic                        w_last;

    assign w_last = (r_cnt == AW'(L - 1));
    assign w_pop  = i_q_valid && (r_state == msls_pkg::ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_done      = 1'b0;
        n_sending   = r_sending;
        n_pre       = r_pre;
        n_slot      = r_slot;
        n_led       = r_led;
        n_bit       = r_bit;
        w_ld_cmd    = 1'b0;
        w_ld_cur    = 1'b0;
        w_pix_we    = '0;
        w_pix_waddr = i_cmd.index;
        w_pix_wdata = i_cmd.grb;
        w_pix_raddr = r_cnt;
        case (r_state)
            msls_pkg::ST_IDLE: begin
                if (w_pop) begin
                    case (i_cmd.op)
                        msls_pkg::OP_PIXEL: begin
                            w_pix_we[i_cmd.strip] = 1'b1;
                            n_done = 1'b1;
                        end
                        msls_pkg::OP_COLUMN: begin
                            w_pix_we = '1;
                            n_done   = 1'b1;
                        end
                        msls_pkg::OP_FILL, msls_pkg::OP_ALL: begin
                            w_ld_cmd = 1'b1;
                            n_cnt    = '0;
                            n_state  = msls_pkg::ST_FILL;
                        end
                        msls_pkg::OP_START: begin
                            n_sending = 1'b1;
                            n_pre     = '0;
                            n_slot    = '0;
                            n_led     = '0;
                            n_bit     = '0;
                            n_cnt     = '0;
                            n_state   = msls_pkg::ST_COPY;
                        end
                        msls_pkg::OP_TICK: begin
                            n_done = 1'b1;
                            if (r_sending) begin
                                if (r_pre >= r_prescale) begin
                                    n_pre = '0;
                                    if (r_slot >= r_period) begin
                                        n_slot = '0;
                                        if (r_led == msls_pkg::LED_W'(L)) begin
                                            // reset slot done
                                            n_sending = 1'b0;
                                            n_led     = '0;
                                            n_bit     = '0;
                                        end else if (r_bit ==
                                                     msls_pkg::BIT_W'(msls_pkg::BITS_PER_LED - 1)) begin
                                            n_bit    = '0;
                                            n_led    = r_led + msls_pkg::LED_W'(1);
                                            w_ld_cur = 1'b1;
                                        end else begin
                                            n_bit = r_bit + msls_pkg::BIT_W'(1);
                                        end
                                    end else begin
                                        n_slot = r_slot + msls_pkg::CFG_W'(1);
                                    end
                                end else begin
                                    n_pre = r_pre + msls_pkg::CFG_W'(1);
                                end
                            end
                        end
                        default: n_done = 1'b1;
                    endcase
                end
            end
            msls_pkg::ST_FILL: begin
                w_pix_waddr = r_cnt;
                w_pix_wdata = r_cmd.grb;
                if (r_cmd.op == msls_pkg::OP_ALL) begin
                    w_pix_we = '1;
                end else begin
                    w_pix_we[r_cmd.strip] = 1'b1;
                end
                if (w_last) begin
                    n_done  = 1'b1;
                    n_state = msls_pkg::ST_IDLE;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            msls_pkg::ST_COPY: begin
                if (w_last) begin
                    n_state = msls_pkg::ST_FLUSH;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            msls_pkg::ST_FLUSH: n_state = msls_pkg::ST_PRIME;
            msls_pkg::ST_PRIME: n_state = msls_pkg::ST_LOAD;
            msls_pkg::ST_LOAD: begin
                w_ld_cur = 1'b1;
                n_done   = 1'b1;
                n_state  = msls_pkg::ST_IDLE;
            end
            default: n_state = msls_pkg::ST_IDLE;
        endcase
    end

    // prefetch the next led while sending, led zero while priming
    assign w_snd_raddr = (r_state == msls_pkg::ST_PRIME) ? '0 : (r_led[AW-1:0] + AW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= msls_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_done    <= 1'b0;
            r_sending <= 1'b0;
            r_pre     <= '0;
            r_slot    <= '0;
            r_led     <= '0;
            r_bit     <= '0;
            r_cpy_wr  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_done    <= n_done;
            r_sending <= n_sending;
            r_pre     <= n_pre;
            r_slot    <= n_slot;
            r_led     <= n_led;
            r_bit     <= n_bit;
            r_cpy_wr  <= (r_state == msls_pkg::ST_COPY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale  <= msls_pkg::DEF_PRESCALE;
            r_period    <= msls_pkg::DEF_SLOT_PERIOD;
            r_zero_high <= msls_pkg::DEF_ZERO_HIGH;
            r_one_high  <= msls_pkg::DEF_ONE_HIGH;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                msls_pkg::CFG_PRESCALE:  r_prescale  <= i_cfg.data;
                msls_pkg::CFG_PERIOD:    r_period    <= i_cfg.data;
                msls_pkg::CFG_ZERO_HIGH: r_zero_high <= i_cfg.data;
                msls_pkg::CFG_ONE_HIGH:  r_one_high  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cpy_addr <= r_cnt;
        if (w_ld_cmd) begin
            r_cmd <= i_cmd;
        end
    end

    genvar g;
    generate
        for (g = 0; g < S; g++) begin : g_strip
            // never-written pixels read as zero
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_pix_vld[g] <= '0;
                end else if (w_pix_we[g]) begin
                    r_pix_vld[g][w_pix_waddr] <= 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                r_vld_q[g] <= r_pix_vld[g][w_pix_raddr];
                if (w_ld_cur) begin
                    r_cur[g] <= w_snd_rdata[g];
                end
            end

            assign w_snd_wdata[g] = r_vld_q[g] ? w_pix_rdata[g] : '0;

            msls_ram #(
                .WIDTH(CW),
                .DEPTH(L)
            ) u_pix_ram (
                .i_clk  (i_clk),
                .i_we   (w_pix_we[g]),
                .i_waddr(w_pix_waddr),
                .i_wdata(w_pix_wdata),
                .i_raddr(w_pix_raddr),
                .o_rdata(w_pix_rdata[g])
            );

            msls_ram #(
                .WIDTH(CW),
                .DEPTH(L)
            ) u_snd_ram (
                .i_clk  (i_clk),
                .i_we   (r_cpy_wr),
                .i_waddr(r_cpy_addr),
                .i_wdata(w_snd_wdata[g]),
                .i_raddr(w_snd_raddr),
                .o_rdata(w_snd_rdata[g])
            );

            assign w_lvl[g] = w_in_data &&
                (r_slot < (r_cur[g][msls_pkg::BIT_W'(msls_pkg::BITS_PER_LED - 1) - r_bit]
                           ? r_one_high : r_zero_high));
        end
    endgenerate

    assign w_in_data     = r_sending && (r_led < msls_pkg::LED_W'(L));
    assign o_line_levels = msls_pkg::LEVELS_W'(w_lvl);
    assign o_busy_res    = r_sending;
    assign o_done        = r_done;
    assign o_pop         = w_pop;
    assign o_sts.idle    = (r_state == msls_pkg::ST_IDLE);
    assign o_sts.sending = r_sending;

endmodule

// ===== rtl/core/multi_strip_rgb_led_serializer.sv =====
// top level of the multi-strip rgb led serializer
//
// drives up to eight led data lines from a pixel store of 5 strips x 16 leds.
// a beat is taken on start while busy is low and lands in a 4-entry command
// queue; busy is high only while that queue is full. the executor behind the
// queue handles one command at a time and reports each one with a one-cycle
// o_done strobe carrying the line levels and transmission status after that
// command; the receiver cannot stall, so o_done must be sampled every cycle.
// per command: tick, single pixel write, write of one position on every
// strip and ignored commands are handled entirely in the idle state, so ticks
// stream at one per cycle while no fill or start runs. strip fill and
// fill-all take the command and then sweep the store one led per cycle.
// start takes the command, copies the pixel store into the send store one
// led per cycle across all strips, then primes the first led word through
// the flush, prime and load states. o_done is registered, raised in the cycle
// after the command completes. the pixel store is cleared at reset through
// per-entry valid bits, so no clearing pass is needed and commands are taken
// right after reset. configuration writes on i_cfg_we take effect at once and
// are expected only while the block is idle.
module multi_strip_rgb_led_serializer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command beat
    input  logic                             start,
    output logic                             busy,
    input  logic [msls_pkg::KIND_W-1:0]      i_kind,
    input  logic [msls_pkg::FIELD_W-1:0]     i_strip,
    input  logic [msls_pkg::FIELD_W-1:0]     i_index,
    input  logic [msls_pkg::FIELD_W-1:0]     i_red,
    input  logic [msls_pkg::FIELD_W-1:0]     i_green,
    input  logic [msls_pkg::FIELD_W-1:0]     i_blue,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [msls_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [msls_pkg::CFG_W-1:0]       i_cfg_wdata,
    // result beat
    output logic                             o_done,
    output logic [msls_pkg::LEVELS_W-1:0]    o_line_levels,
    output logic                             o_busy_res
);

`include "assert_macros.svh"

    logic                    w_push;
    logic                    w_full;
    logic                    w_q_valid;
    logic                    w_pop;
    msls_pkg::t_cmd          w_cmd;
    msls_pkg::t_cfg_wr       w_cfg;
    msls_pkg::t_back_sts     w_sts;

    // a beat is taken whenever the queue has room
    assign w_push = start && !w_full;
    assign busy   = w_full;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = msls_pkg::t_cfg_reg'(i_cfg_idx);
    assign w_cfg.data = i_cfg_wdata;

    // classify and queue
    msls_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_kind (i_kind),
        .i_strip(i_strip),
        .i_index(i_index),
        .i_red  (i_red),
        .i_green(i_green),
        .i_blue (i_blue),
        .i_pop  (w_pop),
        .o_full (w_full),
        .o_valid(w_q_valid),
        .o_cmd  (w_cmd)
    );

    // execute: stores, slot timer, line encoder
    msls_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_q_valid    (w_q_valid),
        .i_cmd        (w_cmd),
        .o_pop        (w_pop),
        .o_sts        (w_sts),
        .o_done       (o_done),
        .o_line_levels(o_line_levels),
        .o_busy_res   (o_busy_res)
    );

    // an accepted beat is waiting in the queue on the next cycle
    `ASSERT_NXT(a_push_lands, i_clk, i_rst_n, w_push, w_q_valid)
    // the executor only takes a command when it is free and one is queued
    `ASSERT_IMP(a_pop_ok, i_clk, i_rst_n, w_pop, w_q_valid && w_sts.idle)
    // lines stay low whenever no transmission runs
    `ASSERT_IMP(a_idle_low, i_clk, i_rst_n, !w_sts.sending, o_line_levels == '0)

endmodule

// ===== verif/tb_multi_strip_rgb_led_serializer.sv =====
`timescale 1ns / 1ps
// testbench of the led serializer: directed and random command beats checked against a line predictor
module tb_multi_strip_rgb_led_serializer;
    import msls_pkg::*;

    // run shape
    localparam int RESET_CYCLES  = 9;
    localparam int STORE_SIZE    = STRIPS * LEDS_PER_STRIP;
    localparam int DATA_SLOTS    = LEDS_PER_STRIP * BITS_PER_LED;
    localparam int STALL_LIMIT   = 2000;   // cycles with neither a command nor a result beat
    localparam int SETTLE_CYCLES = 4;      // quiet cycles before a register write
    localparam int TAIL_CYCLES   = 40;     // watch for stray results after the last one
    localparam int MAX_REPORTS   = 10;
    localparam int HOLD_FOR_DRAIN = -1;    // gap code: stop sending until every result is back

    // kind codes the block ignores
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] strip;
        logic [FIELD_W-1:0] index;
        logic [FIELD_W-1:0] red;
        logic [FIELD_W-1:0] green;
        logic [FIELD_W-1:0] blue;
    } led_cmd_t;

    typedef struct packed {
        logic [LEVELS_W-1:0] levels;
        logic                busy;
    } line_state_t;

    // one directed row; fixed rows carry a hand-written expected beat
    typedef struct packed {
        led_cmd_t    cmd;
        logic        fixed;
        line_state_t want;
    } dir_row_t;

    // dut ports, all inputs known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    logic [KIND_W-1:0]    i_kind      = '0;
    logic [FIELD_W-1:0]   i_strip     = '0;
    logic [FIELD_W-1:0]   i_index     = '0;
    logic [FIELD_W-1:0]   i_red       = '0;
    logic [FIELD_W-1:0]   i_green     = '0;
    logic [FIELD_W-1:0]   i_blue      = '0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 o_done;
    logic [LEVELS_W-1:0]  o_line_levels;
    logic                 o_busy_res;

    // predictor copy of the pixel store, the snapshot being sent and the slot timer
    logic [COLOR_W-1:0] pix_mem  [STORE_SIZE];
    logic [COLOR_W-1:0] snap_mem [STORE_SIZE];
    logic [15:0]        pre_cnt;
    logic [15:0]        slot_cnt;
    logic [12:0]        slot_pos;
    logic               tx_on;
    logic [CFG_W-1:0]   cfg_prescale;
    logic [CFG_W-1:0]   cfg_period;
    logic [CFG_W-1:0]   cfg_zero_high;
    logic [CFG_W-1:0]   cfg_one_high;

    // line beats still owed by the block, oldest first
    line_state_t exp_lines_q [$];
    dir_row_t    dir_rows [$];

    int beats_sent;
    int results_seen;
    int err_count;
    int frames_done;
    int settings_used;
    int burst_left;
    int stall_cycles;

    multi_strip_rgb_led_serializer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_strip       (i_strip),
        .i_index       (i_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_done        (o_done),
        .o_line_levels (o_line_levels),
        .o_busy_res    (o_busy_res)
    );

    // 4 ns clock
    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // line predictor
    // ---------------------------------------------------------------

    function automatic void clear_predictor();
        for (int k = 0; k < STORE_SIZE; k++) begin
            pix_mem[k]  = '0;
            snap_mem[k] = '0;
        end
        pre_cnt       = '0;
        slot_cnt      = '0;
        slot_pos      = '0;
        tx_on         = 1'b0;
        cfg_prescale  = DEF_PRESCALE;
        cfg_period    = DEF_SLOT_PERIOD;
        cfg_zero_high = DEF_ZERO_HIGH;
        cfg_one_high  = DEF_ONE_HIGH;
    endfunction

    // out of range strip or position leaves the store alone
    function automatic void store_pixel(int s, int i, logic [COLOR_W-1:0] grb);
        if (s < STRIPS && i < LEDS_PER_STRIP)
            pix_mem[s * LEDS_PER_STRIP + i] = grb;
    endfunction

    // one timer count; the slot after the last data slot is the low trailer
    function automatic void advance_slot();
        if (slot_cnt >= cfg_period) begin
            slot_cnt = '0;
            slot_pos = slot_pos + 1'b1;
            if (slot_pos > DATA_SLOTS) begin
                slot_pos = '0;
                tx_on    = 1'b0;
                frames_done++;
            end
        end else begin
            slot_cnt = slot_cnt + 1'b1;
        end
    endfunction

    // grb sent msb first; line high while the count is below the bit's high time
    function automatic line_state_t line_levels_now();
        line_state_t      r;
        int               led_no;
        int               bit_no;
        logic [COLOR_W-1:0] word;
        logic [CFG_W-1:0] high_cnt;
        r.levels = '0;
        r.busy   = tx_on;
        if (tx_on && slot_pos < DATA_SLOTS) begin
            led_no = slot_pos / BITS_PER_LED;
            bit_no = BITS_PER_LED - 1 - (slot_pos % BITS_PER_LED);
            for (int s = 0; s < STRIPS; s++) begin
                word     = snap_mem[s * LEDS_PER_STRIP + led_no];
                high_cnt = word[bit_no] ? cfg_one_high : cfg_zero_high;
                if (slot_cnt < high_cnt)
                    r.levels[s] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic line_state_t predict_lines(led_cmd_t c);
        logic [COLOR_W-1:0] grb;
        grb = {c.green, c.red, c.blue};
        case (c.kind)
            KIND_SET_PIXEL: store_pixel(c.strip, c.index, grb);
            KIND_FILL_STRIP: begin
                for (int i = 0; i < LEDS_PER_STRIP; i++)
                    store_pixel(c.strip, i, grb);
            end
            KIND_SET_COLUMN: begin
                for (int s = 0; s < STRIPS; s++)
                    store_pixel(s, c.index, grb);
            end
            KIND_SET_ALL: begin
                for (int s = 0; s < STRIPS; s++)
                    for (int i = 0; i < LEDS_PER_STRIP; i++)
                        store_pixel(s, i, grb);
            end
            KIND_START: begin
                // snapshot and restart, even in the middle of a frame
                for (int k = 0; k < STORE_SIZE; k++)
                    snap_mem[k] = pix_mem[k];
                pre_cnt  = '0;
                slot_cnt = '0;
                slot_pos = '0;
                tx_on    = 1'b1;
            end
            KIND_TICK: begin
                // ticks while idle do nothing
                if (tx_on) begin
                    if (pre_cnt >= cfg_prescale) begin
                        pre_cnt = '0;
                        advance_slot();
                    end else begin
                        pre_cnt = pre_cnt + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return line_levels_now();
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic dir_row_t make_row(logic [KIND_W-1:0] kind, logic [7:0] strip,
                                          logic [7:0] index, logic [7:0] red,
                                          logic [7:0] green, logic [7:0] blue,
                                          logic fixed, logic [LEVELS_W-1:0] levels,
                                          logic busy_exp);
        dir_row_t r;
        r.cmd.kind    = kind;
        r.cmd.strip   = strip;
        r.cmd.index   = index;
        r.cmd.red     = red;
        r.cmd.green   = green;
        r.cmd.blue    = blue;
        r.fixed       = fixed;
        r.want.levels = levels;
        r.want.busy   = busy_exp;
        return r;
    endfunction

    // bursts of back-to-back beats separated by random gaps
    function automatic int next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 40);
        return $urandom_range(1, 12);
    endfunction

    // mostly ticks while a frame is out so frames run to their end;
    // starts and pixel writes while idle; a little noise throughout
    function automatic led_cmd_t pick_command();
        led_cmd_t c;
        int       roll;
        c.strip = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, STRIPS - 1));
        c.index = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, LEDS_PER_STRIP - 1));
        c.red   = 8'($urandom_range(0, 255));
        c.green = 8'($urandom_range(0, 255));
        c.blue  = 8'($urandom_range(0, 255));
        roll    = $urandom_range(0, 99);
        if (tx_on && $urandom_range(0, 499) == 0)
            c.kind = KIND_START;
        else if (tx_on && roll < 88)
            c.kind = KIND_TICK;
        else if (!tx_on && roll < 30)
            c.kind = KIND_START;
        else if (!tx_on && roll < 40)
            c.kind = KIND_TICK;
        else if (roll < 45 || (tx_on && roll >= 98))
            c.kind = ($urandom_range(0, 1) != 0) ? KIND_SPARE_A : KIND_SPARE_B;
        else begin
            case ($urandom_range(0, 3))
                0:       c.kind = KIND_SET_PIXEL;
                1:       c.kind = KIND_FILL_STRIP;
                2:       c.kind = KIND_SET_COLUMN;
                default: c.kind = KIND_SET_ALL;
            endcase
        end
        return c;
    endfunction

    // drive one command beat, wait for it to be taken, log what it should produce
    task automatic send_beat(input led_cmd_t c, input logic fixed, input line_state_t want,
                             input int gap);
        line_state_t got;
        start   <= 1'b1;
        i_kind  <= c.kind;
        i_strip <= c.strip;
        i_index <= c.index;
        i_red   <= c.red;
        i_green <= c.green;
        i_blue  <= c.blue;
        do @(posedge i_clk); while (busy !== 1'b0);
        got = predict_lines(c);
        exp_lines_q.push_back(fixed ? want : got);
        beats_sent++;
        if (gap == HOLD_FOR_DRAIN) begin
            start <= 1'b0;
            while (exp_lines_q.size() != 0) @(posedge i_clk);
        end else if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic put_timing_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            CFG_PRESCALE:  cfg_prescale  = data;
            CFG_PERIOD:    cfg_period    = data;
            CFG_ZERO_HIGH: cfg_zero_high = data;
            CFG_ONE_HIGH:  cfg_one_high  = data;
            default: ;
        endcase
    endtask

    // registers change only with the command queue empty; the frame itself may be mid-flight
    task automatic write_timing(input logic [CFG_W-1:0] prescale, input logic [CFG_W-1:0] period,
                                input logic [CFG_W-1:0] zero_high,
                                input logic [CFG_W-1:0] one_high);
        start <= 1'b0;
        while (exp_lines_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        put_timing_reg(CFG_PRESCALE, prescale);
        put_timing_reg(CFG_PERIOD, period);
        put_timing_reg(CFG_ZERO_HIGH, zero_high);
        put_timing_reg(CFG_ONE_HIGH, one_high);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // random beats, with one full drain somewhere in the middle
    task automatic run_phase(input int n_items);
        int drain_at;
        drain_at = $urandom_range(n_items / 4, (3 * n_items) / 4);
        for (int k = 0; k < n_items; k++)
            send_beat(pick_command(), 1'b0, '0, (k == drain_at) ? HOLD_FOR_DRAIN : next_gap());
    endtask

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    function automatic void log_mismatch(string what);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("mismatch at result %0d: %s", results_seen, what);
    endfunction

    // o_done cannot be held off, so every cycle is sampled
    always @(posedge i_clk) begin : check_lines
        line_state_t want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            results_seen++;
            if (exp_lines_q.size() == 0) begin
                log_mismatch($sformatf("unexpected beat, levels %02h busy %0b",
                                       o_line_levels, o_busy_res));
            end else begin
                want = exp_lines_q.pop_front();
                if (o_line_levels !== want.levels || o_busy_res !== want.busy)
                    log_mismatch($sformatf("expected levels %02h busy %0b, got levels %02h busy %0b",
                                           want.levels, want.busy, o_line_levels, o_busy_res));
            end
        end
    end

    // cycles since the last beat on either side
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        stall_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    initial begin : stimulus
        beats_sent    = 0;
        results_seen  = 0;
        err_count     = 0;
        frames_done   = 0;
        settings_used = 1;
        burst_left    = 0;
        clear_predictor();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset timing; idle rows show dark lines, the
        // first start shows every line high since both high times exceed zero
        dir_rows.push_back(make_row(KIND_TICK,       8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                                    1'b1, 8'h00, 1'b0));   // tick while idle
        dir_rows.push_back(make_row(KIND_SPARE_A,    8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                    1'b1, 8'h00, 1'b0));
        dir_rows.push_back(make_row(KIND_SPARE_B,    8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                                    1'b1, 8'h00, 1'b0));
        dir_rows.push_back(make_row(KIND_SET_ALL,    8'h00, 8'h00, 8'hff, 8'hff, 8'hff,
                                    1'b1, 8'h00, 1'b0));
        dir_rows.push_back(make_row(KIND_SET_PIXEL,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                    1'b1, 8'h00, 1'b0));
        dir_rows.push_back(make_row(KIND_SET_PIXEL,  8'h04, 8'h0f, 8'ha5, 8'h5a, 8'hc3,
                                    1'b1, 8'h00, 1'b0));
        dir_rows.push_back(make_row(KIND_SET_PIXEL,  8'h05, 8'h00, 8'h00, 8'h00, 8'h00,
                                    1'b1, 8'h00, 1'b0));   // strip just past the end
        dir_rows.push_back(make_row(KIND_SET_PIXEL,  8'hff, 8'hff, 8'h00, 8'h00, 8'h00,
                                    1'b1, 8'h00, 1'b0));
        dir_rows.push_back(make_row(KIND_SET_PIXEL,  8'h00, 8'h10, 8'h00, 8'h00, 8'h00,
                                    1'b1, 8'h00, 1'b0));   // position just past the end
        dir_rows.push_back(make_row(KIND_FILL_STRIP, 8'h02, 8'h00, 8'h12, 8'h34, 8'h56,
                                    1'b1, 8'h00, 1'b0));
        dir_rows.push_back(make_row(KIND_FILL_STRIP, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00,
                                    1'b1, 8'h00, 1'b0));
        dir_rows.push_back(make_row(KIND_SET_COLUMN, 8'h00, 8'h07, 8'h80, 8'h01, 8'hfe,
                                    1'b1, 8'h00, 1'b0));
        dir_rows.push_back(make_row(KIND_SET_COLUMN, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00,
                                    1'b1, 8'h00, 1'b0));
        dir_rows.push_back(make_row(KIND_SET_COLUMN, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00,
                                    1'b1, 8'h00, 1'b0));
        dir_rows.push_back(make_row(KIND_START,      8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                                    1'b1, 8'h1f, 1'b1));
        // from here on the predictor decides
        dir_rows.push_back(make_row(KIND_TICK,       8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                    1'b0, 8'h00, 1'b0));
        dir_rows.push_back(make_row(KIND_TICK,       8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                    1'b0, 8'h00, 1'b0));
        dir_rows.push_back(make_row(KIND_SET_PIXEL,  8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
                                    1'b0, 8'h00, 1'b0));   // write while sending
        dir_rows.push_back(make_row(KIND_TICK,       8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                    1'b0, 8'h00, 1'b0));
        dir_rows.push_back(make_row(KIND_START,      8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                    1'b0, 8'h00, 1'b0));   // restart mid frame
        dir_rows.push_back(make_row(KIND_TICK,       8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                    1'b0, 8'h00, 1'b0));
        dir_rows.push_back(make_row(KIND_SPARE_A,    8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                    1'b0, 8'h00, 1'b0));

        foreach (dir_rows[r])
            send_beat(dir_rows[r].cmd, dir_rows[r].fixed, dir_rows[r].want, next_gap());

        // extremes: zero bits high all but the last count of a slot, one bits never high, timer crawls
        write_timing(16'hffff, 16'hffff, 16'hffff, 16'h0000);
        run_phase(60);
        // one count per slot; prescale drops below the running count, frames finish
        write_timing(16'h0000, 16'h0000, 16'h0000, 16'h0001);
        run_phase(600);
        write_timing(16'h0001, 16'h0002, 16'h0001, 16'hffff);
        run_phase(200);
        write_timing(16'h0000, 16'h0001, 16'hffff, 16'h0001);
        run_phase(150);
        write_timing(DEF_PRESCALE, DEF_SLOT_PERIOD, DEF_ZERO_HIGH, DEF_ONE_HIGH);
        run_phase(50);

        // drain, then watch a while for stray beats
        start <= 1'b0;
        while (exp_lines_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d command beats (%0d directed) under %0d timing settings",
                 beats_sent, dir_rows.size(), settings_used);
        $display("checked %0d line beats, %0d frames ran to the trailer, %0d mismatches",
                 results_seen, frames_done, err_count);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
